// ----- src/wsc_pkg.sv -----
// Package for the weighted score combiner: widths, register and mode codes,
// configuration and queue entry types, and the Q16.16 rounding and saturation helpers.
// Depends on nothing; every other file of the block but wsc_channels imports it.
package wsc_pkg;

  localparam int NUM_EVALUATORS = 4;
  localparam int MAX_SLOTS      = 16;
  localparam int DATA_W         = 32;
  localparam int EVAL_IDX_W     = (NUM_EVALUATORS > 1) ? $clog2(NUM_EVALUATORS) : 1;
  localparam int SLOT_POS_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SLOT_CNT_W     = 5;
  localparam int EVAL_CNT_W     = 3;
  localparam int MODE_W         = 3;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int REG_IDX_W      = 3;
  localparam int APB_ADDR_W     = 5;
  localparam int WIDE_W         = 48;

  // Combination modes.
  localparam logic [MODE_W-1:0] MODE_SUM   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BSUM  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PROD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MAX   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BMAX  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MIN   = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_EVALS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SLOTS   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT0 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT1 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT2 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT3 = 3'd6;

  localparam logic [MODE_W-1:0]     RST_MODE  = MODE_SUM;
  localparam logic [EVAL_CNT_W-1:0] RST_EVALS = 3'd4;
  localparam logic [SLOT_CNT_W-1:0] RST_SLOTS = 5'd7;

  // Q16.16 values. The most negative code stands for minus infinity.
  localparam logic signed [DATA_W-1:0] NEG_INF = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] FIN_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] FIN_MIN = 32'sh8000_0001;
  localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [2*DATA_W-1:0] Q_HALF = 64'sd32768;

  typedef struct packed {
    logic [MODE_W-1:0]                  mode;
    logic [EVAL_CNT_W-1:0]              evals_in_use;
    logic [SLOT_CNT_W-1:0]              slots_per_cell;
    logic [NUM_EVALUATORS-1:0][DATA_W-1:0] weights;
  } cfg_t;

  typedef struct packed {
    logic [NUM_EVALUATORS-1:0][DATA_W-1:0] scores;
    logic                                  allowed;
    logic [EVAL_IDX_W-1:0]                 last_idx;
  } slot_entry_t;

  // Clamp a wide signed value to the finite Q16.16 range.
  function automatic logic signed [DATA_W-1:0] sat_fin(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > WIDE_W'(FIN_MAX)) begin
      r = FIN_MAX;
    end else if (v < WIDE_W'(FIN_MIN)) begin
      r = FIN_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Round a raw 64-bit Q32.32 product half up to Q16.16 and saturate it.
  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [2*DATA_W-1:0] p);
    logic signed [2*DATA_W-1:0] r;
    logic signed [WIDE_W-1:0]   f;
    r = p + Q_HALF;
    f = r[2*DATA_W-1:16];
    return sat_fin(f);
  endfunction

endpackage

// ----- src/wsc_channels.sv -----
// Handshake channels of the weighted score combiner: the slot score channel
// and the combined result channel. Fixed field widths; no package needed.
interface wsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] score_zero;
  logic signed [31:0] score_one;
  logic signed [31:0] score_two;
  logic signed [31:0] score_three;

  modport source (output valid, score_zero, score_one, score_two, score_three, input ready);
  modport sink   (input valid, score_zero, score_one, score_two, score_three, output ready);
endinterface

interface wsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] combined_weight;
  logic               slot_allowed;
  logic               cell_last;

  modport source (output valid, combined_weight, slot_allowed, cell_last, input ready);
  modport sink   (input valid, combined_weight, slot_allowed, cell_last, output ready);
endinterface

// ----- src/wsc_front.sv -----
// Front end of the combiner: accepts slot transactions and classifies them
// (active evaluator count, allowed flag). Depends on wsc_pkg and wsc_channels.
module wsc_front (
  wsc_in_if.sink                      in_ch,
  input  logic [wsc_pkg::EVAL_CNT_W-1:0] evals_in_use,
  output logic                        push_valid,
  input  logic                        push_ready,
  output wsc_pkg::slot_entry_t        push_data
);
  import wsc_pkg::*;

  logic [NUM_EVALUATORS-1:0][DATA_W-1:0] scores;
  logic [EVAL_CNT_W-1:0]                 n_eff;
  logic                                  allowed;

  always_comb begin
    scores[0] = in_ch.score_zero;
    scores[1] = in_ch.score_one;
    scores[2] = in_ch.score_two;
    scores[3] = in_ch.score_three;
  end

  // A count of zero means one score, anything above the evaluator count means all.
  always_comb begin
    if (evals_in_use == '0) begin
      n_eff = EVAL_CNT_W'(1);
    end else if (evals_in_use > EVAL_CNT_W'(NUM_EVALUATORS)) begin
      n_eff = EVAL_CNT_W'(NUM_EVALUATORS);
    end else begin
      n_eff = evals_in_use;
    end
  end

  always_comb begin
    allowed = 1'b1;
    for (int i = 0; i < NUM_EVALUATORS; i++) begin
      if (EVAL_CNT_W'(i) < n_eff && $signed(scores[i]) <= 0) begin
        allowed = 1'b0;
      end
    end
  end

  assign push_valid         = in_ch.valid;
  assign in_ch.ready        = push_ready;
  assign push_data.scores   = scores;
  assign push_data.allowed  = allowed;
  assign push_data.last_idx = EVAL_IDX_W'(n_eff - EVAL_CNT_W'(1));

endmodule

// ----- src/wsc_queue.sv -----
// Short queue of classified slots between the front end and the back end.
// Depends on wsc_pkg for the entry type and depth.
module wsc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  wsc_pkg::slot_entry_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output wsc_pkg::slot_entry_t pop_data
);
  import wsc_pkg::*;

  slot_entry_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> pop_valid)
    else $error("queue empty right after a lone push");

endmodule

// ----- src/wsc_back.sv -----
// Back end of the combiner: scales and combines one queued slot with a shared
// multiplier, keeps the running total and slot position, and drives the result.
// Depends on wsc_pkg and wsc_channels.
module wsc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  wsc_pkg::cfg_t        cfg,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  wsc_pkg::slot_entry_t pop_data,
  wsc_out_if.source            out_ch
);
  import wsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_SCALE, S_RND_SCALE, S_MUL_PROD, S_RND_PROD, S_SELECT, S_DELIVER
  } state_t;

  state_t                     state;
  slot_entry_t                cur;
  logic [EVAL_IDX_W-1:0]      idx;
  logic signed [2*DATA_W-1:0] mul_p;
  logic signed [DATA_W-1:0]   scaled;
  logic signed [DATA_W-1:0]   prod_acc;
  logic signed [DATA_W+1:0]   sum_acc;
  logic signed [DATA_W-1:0]   mx;
  logic signed [DATA_W-1:0]   mn;
  logic signed [DATA_W-1:0]   slot_value;
  logic                       slot_cum;
  logic signed [DATA_W-1:0]   running_total;
  logic [SLOT_POS_W-1:0]      slot_pos;
  logic                       out_valid;
  logic signed [DATA_W-1:0]   out_weight;
  logic                       out_allowed;
  logic                       out_last;

  logic signed [DATA_W-1:0]   mul_a;
  logic signed [DATA_W-1:0]   mul_b;
  logic signed [DATA_W-1:0]   sum_sat;
  logic signed [DATA_W-1:0]   sel_value;
  logic                       sel_cum;
  logic signed [DATA_W-1:0]   total_next;
  logic [SLOT_CNT_W-1:0]      slots_eff;
  logic [SLOT_CNT_W-1:0]      pos_inc;
  logic                       last_w;
  logic                       deliver;

  assign pop_ready = (state == S_IDLE);

  // One multiplier serves both the weight scaling and the product chain.
  always_comb begin
    if (state == S_MUL_SCALE) begin
      mul_a = cur.scores[idx];
      mul_b = cfg.weights[idx];
    end else begin
      mul_a = prod_acc;
      mul_b = scaled;
    end
  end

  always_comb begin
    sum_sat = sat_fin(WIDE_W'(sum_acc));
    unique case (cfg.mode)
      MODE_SUM: begin
        sel_value = sum_sat;
        sel_cum   = 1'b0;
      end
      MODE_BSUM: begin
        sel_value = cur.allowed ? sum_sat : '0;
        sel_cum   = 1'b1;
      end
      MODE_PROD: begin
        sel_value = prod_acc;
        sel_cum   = 1'b1;
      end
      MODE_MAX: begin
        sel_value = mx;
        sel_cum   = 1'b0;
      end
      MODE_BMAX: begin
        sel_value = cur.allowed ? mx : NEG_INF;
        sel_cum   = 1'b1;
      end
      MODE_MIN: begin
        sel_value = mn;
        sel_cum   = 1'b1;
      end
      default: begin
        sel_value = '0;
        sel_cum   = 1'b0;
      end
    endcase
  end

  // Running sum: minus infinity on either side sticks until the group ends.
  always_comb begin
    if (slot_pos == '0) begin
      total_next = slot_value;
    end else if (running_total == NEG_INF || slot_value == NEG_INF) begin
      total_next = NEG_INF;
    end else begin
      total_next = sat_fin(WIDE_W'(running_total) + WIDE_W'(slot_value));
    end
  end

  always_comb begin
    if (cfg.slots_per_cell == '0) begin
      slots_eff = SLOT_CNT_W'(1);
    end else if (cfg.slots_per_cell > SLOT_CNT_W'(MAX_SLOTS)) begin
      slots_eff = SLOT_CNT_W'(MAX_SLOTS);
    end else begin
      slots_eff = cfg.slots_per_cell;
    end
    pos_inc = SLOT_CNT_W'(slot_pos) + SLOT_CNT_W'(1);
    last_w  = (pos_inc >= slots_eff);
  end

  assign deliver = (state == S_DELIVER) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      running_total <= '0;
      slot_pos      <= '0;
    end else begin
      if (out_valid && out_ch.ready && !deliver) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            cur      <= pop_data;
            idx      <= '0;
            prod_acc <= Q_ONE;
            sum_acc  <= '0;
            mx       <= NEG_INF;
            mn       <= FIN_MAX;
            state    <= S_MUL_SCALE;
          end
        end
        S_MUL_SCALE: begin
          mul_p <= mul_a * mul_b;
          state <= S_RND_SCALE;
        end
        S_RND_SCALE: begin
          scaled <= round_sat(mul_p);
          state  <= S_MUL_PROD;
        end
        S_MUL_PROD: begin
          mul_p   <= mul_a * mul_b;
          sum_acc <= sum_acc + (DATA_W + 2)'(scaled);
          if (scaled > mx) begin
            mx <= scaled;
          end
          if (scaled < mn) begin
            mn <= scaled;
          end
          state <= S_RND_PROD;
        end
        S_RND_PROD: begin
          prod_acc <= round_sat(mul_p);
          if (idx == cur.last_idx) begin
            state <= S_SELECT;
          end else begin
            idx   <= idx + EVAL_IDX_W'(1);
            state <= S_MUL_SCALE;
          end
        end
        S_SELECT: begin
          slot_value <= sel_value;
          slot_cum   <= sel_cum;
          state      <= S_DELIVER;
        end
        S_DELIVER: begin
          if (deliver) begin
            if (slot_cum) begin
              running_total <= total_next;
              out_weight    <= total_next;
            end else begin
              out_weight <= slot_value;
            end
            out_allowed <= cur.allowed;
            out_last    <= last_w;
            slot_pos    <= last_w ? '0 : SLOT_POS_W'(pos_inc);
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.combined_weight = out_weight;
  assign out_ch.slot_allowed    = out_allowed;
  assign out_ch.cell_last       = out_last;

  a_group_wrap: assert property (@(posedge clk) disable iff (rst)
    (deliver && last_w) |=> (slot_pos == '0 && out_ch.cell_last))
    else $error("slot position did not wrap at the last slot of a group");

  a_total_kept: assert property (@(posedge clk) disable iff (rst)
    (deliver && !slot_cum) |=> $stable(running_total))
    else $error("running total changed in a non-cumulating mode");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_SCALE) |-> (idx <= cur.last_idx))
    else $error("evaluator index past the active count");

endmodule

// ----- src/weighted_score_combiner.sv -----
// Top level of the weighted score combiner: configuration registers on an APB
// port, front end, slot queue and back end. Depends on wsc_pkg, wsc_channels,
// wsc_front, wsc_queue and wsc_back.
//
//   Channel   Direction  Transaction carries
//   --------  ---------  -----------------------------------------------------
//   in_ch     sink       score_zero..score_three, signed Q16.16, one slot
//   out_ch    source     combined_weight (Q16.16), slot_allowed, cell_last
//   APB       slave      mode, evals_in_use, slots_per_cell, weight_zero..three
//
// Each slot passes through the back end in order: it is taken from the queue,
// then each active evaluator goes through the single shared 32x32 multiplier
// (scale, round, chain the product, round), then the mode's value is picked,
// and the running total is updated as the result is delivered.
// Reset is synchronous and active high; it restores the register defaults and
// clears the running total, the slot position, the queue and the output.
// The queue takes two slots, so the input accepts up to two of them while the back end
// works or while a finished result waits for out_ch.ready.
module weighted_score_combiner (
  input  logic                            clk,
  input  logic                            rst,
  wsc_in_if.sink                          in_ch,
  wsc_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wsc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import wsc_pkg::*;

  cfg_t                 cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;

  logic                 push_valid;
  logic                 push_ready;
  slot_entry_t          push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  slot_entry_t          pop_data;

  // Registers sit on word addresses; the low two address bits are ignored.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Writes beyond the register list fall into the default arm and are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= RST_MODE;
      cfg.evals_in_use   <= RST_EVALS;
      cfg.slots_per_cell <= RST_SLOTS;
      cfg.weights        <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_MODE:    cfg.mode           <= pwdata[MODE_W-1:0];
        REG_EVALS:   cfg.evals_in_use   <= pwdata[EVAL_CNT_W-1:0];
        REG_SLOTS:   cfg.slots_per_cell <= pwdata[SLOT_CNT_W-1:0];
        REG_WEIGHT0: cfg.weights[0]     <= pwdata;
        REG_WEIGHT1: cfg.weights[1]     <= pwdata;
        REG_WEIGHT2: cfg.weights[2]     <= pwdata;
        REG_WEIGHT3: cfg.weights[3]     <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:    prdata = 32'(cfg.mode);
      REG_EVALS:   prdata = 32'(cfg.evals_in_use);
      REG_SLOTS:   prdata = 32'(cfg.slots_per_cell);
      REG_WEIGHT0: prdata = cfg.weights[0];
      REG_WEIGHT1: prdata = cfg.weights[1];
      REG_WEIGHT2: prdata = cfg.weights[2];
      REG_WEIGHT3: prdata = cfg.weights[3];
      default:     prdata = '0;
    endcase
  end

  wsc_front u_front (
    .in_ch        (in_ch),
    .evals_in_use (cfg.evals_in_use),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  wsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  wsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule
